FILE: rtl/core/keyframe_drop_gate_with_rate_estimate_unit_assert.svh
// Assertion macros shared by the keyframe drop gate RTL.
`ifndef KEYFRAME_DROP_GATE_WITH_RATE_ESTIMATE_UNIT_ASSERT_SVH
`define KEYFRAME_DROP_GATE_WITH_RATE_ESTIMATE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define KDGRE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kdgre assertion failed");

// Next-cycle implication, disabled while reset is high.
`define KDGRE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kdgre assertion failed");

`endif

FILE: rtl/core/kdgre_pkg.sv
// Shared types and constants of the keyframe drop gate with rate estimate.
package kdgre_pkg;

   localparam int RING_DEPTH_DEF = 30;
   localparam int RATE_SCALE     = 1000000;
   localparam int DUR_W          = 8;
   localparam int DUR_MAX        = (1 << DUR_W) - 1;
   localparam int RATE_W         = 20;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;

   localparam logic [DUR_W-1:0] MAX_DUR_RESET      = 8'd200;
   localparam logic [DUR_W-1:0] DEFAULT_RATE_RESET = 8'd15;

   // register index, taken from paddr[2]
   localparam logic REG_MAX_DUR      = 1'b0;
   localparam logic REG_DEFAULT_RATE = 1'b1;

   localparam logic [1:0] KIND_AUDIO = 2'd0;
   localparam logic [1:0] KIND_AVC   = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SLOT,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

FILE: rtl/core/keyframe_drop_gate_with_rate_estimate_unit.sv
// Keyframe drop gate with frame-rate estimate: top level.
// Per word: accept, a slot write when the gap is logged, a multiply, then a restoring
// divide of NUM_W quotient bits (skipped when the ring is empty) and the result register.
// One word in flight: a new word is taken once the last result sits in the output register.
// Duration ring in a one-port sync RAM; reset (sync, active high) clears control and slot
// valid bits, loads config reset values, no clearing pass; a word is taken right after reset.
`include "keyframe_drop_gate_with_rate_estimate_unit_assert.svh"

module keyframe_drop_gate_with_rate_estimate_unit #(
   parameter int RING_DEPTH = kdgre_pkg::RING_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_stream_kind,
   input  logic signed [63:0]                   req_pts,
   input  logic signed [31:0]                   req_frame_num,
   input  logic                                 req_idr_flag,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_drop,
   output logic [kdgre_pkg::RATE_W-1:0]         rsp_rate_estimate,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [kdgre_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [kdgre_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [kdgre_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                 pready
);

   localparam int DUR_W     = kdgre_pkg::DUR_W;
   localparam int RATE_W    = kdgre_pkg::RATE_W;
   localparam int POS_W     = $clog2(RING_DEPTH);
   localparam int CNT_W     = $clog2(RING_DEPTH + 1);
   localparam int TOTAL_W   = $clog2(RING_DEPTH * kdgre_pkg::DUR_MAX + 1);
   localparam int NUM_W     = $clog2(RING_DEPTH * kdgre_pkg::RATE_SCALE + 1);
   localparam int DIVC_W    = $clog2(NUM_W);
   localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(RING_DEPTH - 1);
   localparam logic [DIVC_W-1:0] DIVC_LAST = DIVC_W'(NUM_W - 1);
   localparam logic [NUM_W-1:0]  SCALE_N   = NUM_W'(kdgre_pkg::RATE_SCALE);

   // config
   logic [DUR_W-1:0]  max_dur_ff, max_dur_in;
   logic [DUR_W-1:0]  def_rate_ff, def_rate_in;

   // gate and stamp state
   kdgre_pkg::state_type state_ff, state_in;
   logic              waiting_ff, waiting_in;
   logic [32:0]       last_num_ff, last_num_in;
   logic [63:0]       last_stamp_ff, last_stamp_in;
   logic              stamp_valid_ff, stamp_valid_in;

   // ring bookkeeping
   logic [RING_DEPTH-1:0] slot_valid_ff, slot_valid_in;
   logic [POS_W-1:0]  ring_pos_ff, ring_pos_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // per-word work registers
   logic [DUR_W-1:0]  dur_ff, dur_in;
   logic              drop_ff, drop_in;
   logic              use_def_ff, use_def_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [TOTAL_W-1:0] rem_ff, rem_in;
   logic [DIVC_W-1:0] divc_ff, divc_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_drop_ff, rsp_drop_in;
   logic [RATE_W-1:0] rsp_rate_ff, rsp_rate_in;

   // ring memory
   logic [DUR_W-1:0]  ring_mem [RING_DEPTH];
   logic [DUR_W-1:0]  mem_rd_ff;
   logic              slot_wr;

   // combinational helpers
   logic              accept;
   logic              csr_wr;
   logic              pkt_ok;
   logic [63:0]       pts_diff;
   logic              diff_nonpos;
   logic              diff_small;
   logic signed [33:0] fn_wide;
   logic signed [33:0] next_expected;
   logic              wait_now;
   logic [DUR_W-1:0]  old_dur;
   logic [TOTAL_W:0]  trial;
   logic              qbit;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == kdgre_pkg::ST_IDLE);
   assign csr_wr    = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == kdgre_pkg::REG_DEFAULT_RATE)
                      ? {{(kdgre_pkg::CSR_DATA_W-DUR_W){1'b0}}, def_rate_ff}
                      : {{(kdgre_pkg::CSR_DATA_W-DUR_W){1'b0}}, max_dur_ff};

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drop          = rsp_drop_ff;
   assign rsp_rate_estimate = rsp_rate_ff;

   assign pkt_ok      = (req_frame_num != -32'sd1) && (req_stream_kind != kdgre_pkg::KIND_AUDIO);
   assign pts_diff    = $unsigned(req_pts) - last_stamp_ff;
   assign diff_nonpos = pts_diff[63] || (pts_diff == 64'd0);
   assign diff_small  = pts_diff <= {{(64-DUR_W){1'b0}}, max_dur_ff};
   assign fn_wide       = {{2{req_frame_num[31]}}, req_frame_num};
   assign next_expected = $signed({last_num_ff[32], last_num_ff}) + 34'sd1;
   assign wait_now      = waiting_ff || last_num_ff[32] || (fn_wide > next_expected);

   assign old_dur = slot_valid_ff[ring_pos_ff] ? mem_rd_ff : '0;
   assign trial   = {rem_ff, num_ff[NUM_W-1]};
   assign qbit    = trial >= {1'b0, total_ff};
   assign slot_wr = (state_ff == kdgre_pkg::ST_SLOT);

   always_comb begin
      state_in       = state_ff;
      max_dur_in     = max_dur_ff;
      def_rate_in    = def_rate_ff;
      waiting_in     = waiting_ff;
      last_num_in    = last_num_ff;
      last_stamp_in  = last_stamp_ff;
      stamp_valid_in = stamp_valid_ff;
      slot_valid_in  = slot_valid_ff;
      ring_pos_in    = ring_pos_ff;
      total_in       = total_ff;
      count_in       = count_ff;
      dur_in         = dur_ff;
      drop_in        = drop_ff;
      use_def_in     = use_def_ff;
      num_in         = num_ff;
      rem_in         = rem_ff;
      divc_in        = divc_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_drop_in    = rsp_drop_ff;
      rsp_rate_in    = rsp_rate_ff;

      if (csr_wr) begin
         if (paddr[2] == kdgre_pkg::REG_DEFAULT_RATE) begin
            def_rate_in = pwdata[DUR_W-1:0];
         end else begin
            max_dur_in = pwdata[DUR_W-1:0];
         end
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         kdgre_pkg::ST_IDLE: begin
            if (accept) begin
               drop_in  = 1'b0;
               state_in = kdgre_pkg::ST_MUL;
               if (pkt_ok) begin
                  if (!stamp_valid_ff) begin
                     ring_pos_in = '0;
                  end else if (diff_nonpos || diff_small) begin
                     // ram holds mem[ring_pos] by the next cycle
                     dur_in   = diff_nonpos ? '0 : pts_diff[DUR_W-1:0];
                     state_in = kdgre_pkg::ST_SLOT;
                  end
                  last_stamp_in  = $unsigned(req_pts);
                  stamp_valid_in = 1'b1;
                  if (req_stream_kind == kdgre_pkg::KIND_AVC) begin
                     waiting_in = wait_now && !req_idr_flag;
                     drop_in    = wait_now && !req_idr_flag;
                  end
                  last_num_in = {req_frame_num[31], req_frame_num};
               end
            end
         end
         kdgre_pkg::ST_SLOT: begin
            total_in = total_ff - TOTAL_W'(old_dur) + TOTAL_W'(dur_ff);
            count_in = count_ff - CNT_W'(old_dur != '0) + CNT_W'(dur_ff != '0);
            slot_valid_in[ring_pos_ff] = 1'b1;
            ring_pos_in = (ring_pos_ff == POS_LAST) ? '0 : ring_pos_ff + 1'b1;
            state_in = kdgre_pkg::ST_MUL;
         end
         kdgre_pkg::ST_MUL: begin
            use_def_in = (count_ff == '0) || (total_ff == '0);
            num_in     = NUM_W'(count_ff) * SCALE_N;
            rem_in     = '0;
            divc_in    = '0;
            state_in   = use_def_in ? kdgre_pkg::ST_DONE : kdgre_pkg::ST_DIV;
         end
         kdgre_pkg::ST_DIV: begin
            // restoring divide, quotient bits shift into num
            rem_in  = qbit ? TOTAL_W'(trial - {1'b0, total_ff}) : trial[TOTAL_W-1:0];
            num_in  = {num_ff[NUM_W-2:0], qbit};
            divc_in = divc_ff + 1'b1;
            if (divc_ff == DIVC_LAST) begin
               state_in = kdgre_pkg::ST_DONE;
            end
         end
         kdgre_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_drop_in  = drop_ff;
               rsp_rate_in  = use_def_ff ? {{(RATE_W-DUR_W){1'b0}}, def_rate_ff}
                                         : num_ff[RATE_W-1:0];
               state_in     = kdgre_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kdgre_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= kdgre_pkg::ST_IDLE;
         max_dur_ff     <= kdgre_pkg::MAX_DUR_RESET;
         def_rate_ff    <= kdgre_pkg::DEFAULT_RATE_RESET;
         waiting_ff     <= 1'b1;
         last_num_ff    <= '1;
         last_stamp_ff  <= '0;
         stamp_valid_ff <= 1'b0;
         slot_valid_ff  <= '0;
         ring_pos_ff    <= '0;
         total_ff       <= '0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         max_dur_ff     <= max_dur_in;
         def_rate_ff    <= def_rate_in;
         waiting_ff     <= waiting_in;
         last_num_ff    <= last_num_in;
         last_stamp_ff  <= last_stamp_in;
         stamp_valid_ff <= stamp_valid_in;
         slot_valid_ff  <= slot_valid_in;
         ring_pos_ff    <= ring_pos_in;
         total_ff       <= total_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dur_ff      <= dur_in;
      drop_ff     <= drop_in;
      use_def_ff  <= use_def_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      divc_ff     <= divc_in;
      rsp_drop_ff <= rsp_drop_in;
      rsp_rate_ff <= rsp_rate_in;
   end

   always_ff @(posedge clock) begin
      if (slot_wr) begin
         ring_mem[ring_pos_ff] <= dur_ff;
      end
      mem_rd_ff <= ring_mem[ring_pos_ff];
   end

   `KDGRE_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(RING_DEPTH))
   `KDGRE_ASSERT_NOW(a_count_total, clock, reset, 1'b1,
                     (count_ff == '0) == (total_ff == '0))
   `KDGRE_ASSERT_NOW(a_rate_range, clock, reset, rsp_valid_ff,
                     rsp_rate_ff <= RATE_W'(kdgre_pkg::RATE_SCALE))
   `KDGRE_ASSERT_NEXT(a_one_in_flight, clock, reset, accept, !req_ready)

endmodule

FILE: dv/keyframe_gate_checker.sv
`timescale 1ns / 1ps
// Checker for the keyframe drop gate: predicts every result word and compares it.
module keyframe_gate_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [1:0]                           req_stream_kind,
   input  logic [63:0]                          req_pts,
   input  logic signed [31:0]                   req_frame_num,
   input  logic                                 req_idr_flag,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic                                 rsp_drop,
   input  logic [kdgre_pkg::RATE_W-1:0]         rsp_rate_estimate,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic                                 pready,
   input  logic [kdgre_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [kdgre_pkg::CSR_DATA_W-1:0]     pwdata,
   output int                                   mismatch_count,
   output int                                   verdicts_pending
);

   localparam int SLOT_COUNT = kdgre_pkg::RING_DEPTH_DEF;

   typedef struct packed {
      logic                        drop;
      logic [kdgre_pkg::RATE_W-1:0] rate;
   } verdict_type;

   logic [7:0]  max_dur_copy;
   logic [7:0]  default_rate_copy;
   logic        key_wait;
   longint      last_number;
   logic [63:0] last_stamp;
   logic        stamp_seen;
   logic [7:0]  slots [SLOT_COUNT];
   int          slot_pos;
   int          slot_sum;
   int          slot_count;
   int          results_seen;
   verdict_type expected_verdicts [$];

   initial mismatch_count = 0;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch on result %0d, %s: got %0d, want %0d", results_seen, what, got, want);
      mismatch_count++;
   endtask

   task automatic log_duration(input logic [7:0] d);
      if (slots[slot_pos] != 8'd0) begin
         slot_sum -= int'(slots[slot_pos]);
         slot_count--;
      end
      slots[slot_pos] = d;
      if (d != 8'd0) begin
         slot_sum += int'(d);
         slot_count++;
      end
      slot_pos = (slot_pos + 1) % SLOT_COUNT;
   endtask

   function automatic logic [kdgre_pkg::RATE_W-1:0] current_rate();
      longint quotient;
      if (slot_count == 0 || slot_sum == 0) begin
         return {12'd0, default_rate_copy};
      end
      quotient = (longint'(slot_count) * longint'(kdgre_pkg::RATE_SCALE)) / longint'(slot_sum);
      return quotient[kdgre_pkg::RATE_W-1:0];
   endfunction

   task automatic predict_packet(input logic [1:0] kind, input logic [63:0] pts,
                                 input logic signed [31:0] fn, input logic idr,
                                 output verdict_type v);
      logic [63:0] diff;
      longint      num;
      num    = longint'(fn);
      v.drop = 1'b0;
      if (num != -1 && kind != kdgre_pkg::KIND_AUDIO) begin
         if (!stamp_seen) begin
            slot_pos = 0;
         end else begin
            diff = pts - last_stamp;
            // non-positive gaps still advance the ring, as empty slots
            if (diff[63] || diff == 64'd0) begin
               log_duration(8'd0);
            end else if (diff <= {56'd0, max_dur_copy}) begin
               log_duration(diff[7:0]);
            end
         end
         last_stamp = pts;
         stamp_seen = 1'b1;
         if (kind == kdgre_pkg::KIND_AVC) begin
            if (last_number < 0 || num > last_number + 1) begin
               key_wait = 1'b1;
            end
            if (key_wait) begin
               if (idr) begin
                  key_wait = 1'b0;
               end else begin
                  v.drop = 1'b1;
               end
            end
         end
         last_number = num;
      end
      v.rate = current_rate();
   endtask

   always @(posedge clock) begin
      verdict_type want;
      verdict_type fresh;
      if (reset) begin
         max_dur_copy      = kdgre_pkg::MAX_DUR_RESET;
         default_rate_copy = kdgre_pkg::DEFAULT_RATE_RESET;
         key_wait          = 1'b1;
         last_number       = -1;
         last_stamp        = 64'd0;
         stamp_seen        = 1'b0;
         for (int k = 0; k < SLOT_COUNT; k++) begin
            slots[k] = 8'd0;
         end
         slot_pos     = 0;
         slot_sum     = 0;
         slot_count   = 0;
         results_seen = 0;
         expected_verdicts.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch("word with nothing expected, rate", longint'(rsp_rate_estimate), 0);
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_drop !== want.drop) begin
                  report_mismatch("drop", longint'(rsp_drop), longint'(want.drop));
               end
               if (rsp_rate_estimate !== want.rate) begin
                  report_mismatch("rate_estimate", longint'(rsp_rate_estimate),
                                  longint'(want.rate));
               end
            end
            results_seen++;
         end
         if (req_valid && req_ready) begin
            predict_packet(req_stream_kind, req_pts, req_frame_num, req_idr_flag, fresh);
            expected_verdicts.push_back(fresh);
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr[2])
               kdgre_pkg::REG_MAX_DUR: begin
                  max_dur_copy = pwdata[7:0];
               end
               kdgre_pkg::REG_DEFAULT_RATE: begin
                  default_rate_copy = pwdata[7:0];
               end
               default: begin
               end
            endcase
         end
      end
      verdicts_pending <= expected_verdicts.size();
   end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// Top of the keyframe drop gate testbench: clock, reset, stimulus and verdict.
module testbench;

   localparam int         CYCLE_LIMIT      = 1000000;
   localparam int         PHASE_ITEMS      = 105;
   localparam int         DRAIN_CYCLES     = 64;
   localparam int         LONG_HOLD_CYCLES = 600;
   localparam logic [1:0] KIND_OTHER_VIDEO = 2'd2;
   localparam logic [1:0] KIND_SPARE       = 2'd3;

   logic                   clock           = 1'b0;
   logic                   reset           = 1'b1;
   logic                   req_valid       = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_stream_kind = 2'd0;
   logic signed [63:0]     req_pts         = 64'd0;
   logic signed [31:0]     req_frame_num   = 32'd0;
   logic                   req_idr_flag    = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready       = 1'b0;
   logic                   rsp_drop;
   logic [kdgre_pkg::RATE_W-1:0]     rsp_rate_estimate;
   logic                   psel            = 1'b0;
   logic                   penable         = 1'b0;
   logic                   pwrite          = 1'b0;
   logic [kdgre_pkg::CSR_ADDR_W-1:0] paddr  = '0;
   logic [kdgre_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [kdgre_pkg::CSR_DATA_W-1:0] prdata;
   logic                   pready;

   int          mismatch_count;
   int          verdicts_pending;
   int          cycle_count = 0;
   longint      gen_fn;
   logic [63:0] gen_pts;

   keyframe_drop_gate_with_rate_estimate_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_stream_kind   (req_stream_kind),
      .req_pts           (req_pts),
      .req_frame_num     (req_frame_num),
      .req_idr_flag      (req_idr_flag),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_drop          (rsp_drop),
      .rsp_rate_estimate (rsp_rate_estimate),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   keyframe_gate_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_stream_kind   (req_stream_kind),
      .req_pts           (req_pts),
      .req_frame_num     (req_frame_num),
      .req_idr_flag      (req_idr_flag),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_drop          (rsp_drop),
      .rsp_rate_estimate (rsp_rate_estimate),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .pready            (pready),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .mismatch_count    (mismatch_count),
      .verdicts_pending  (verdicts_pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // result side: random stalls, plus two long holds that back the block up
   initial begin : result_sink
      int hold_left;
      int mode;
      int mode_left;
      int got;
      int long_holds;
      hold_left  = 0;
      mode       = 0;
      mode_left  = 0;
      got        = 0;
      long_holds = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got++;
         end
         if (mode_left == 0) begin
            mode      = int'($urandom_range(0, 2));
            mode_left = int'($urandom_range(20, 120));
         end else begin
            mode_left--;
         end
         if (hold_left == 0) begin
            if (long_holds < 2 && got >= 100 + 300 * long_holds) begin
               hold_left = LONG_HOLD_CYCLES;
               long_holds++;
            end else if (mode != 0) begin
               if ($urandom_range(0, 99) < 20) begin
                  hold_left = int'($urandom_range(1, 3));
               end else if ($urandom_range(0, 99) < 3) begin
                  hold_left = int'($urandom_range(10, 60));
               end
            end
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // offer one packet word, wait for it to be taken, then maybe idle
   task automatic send_word(input logic [1:0] kind, input logic [63:0] pts,
                            input longint fn, input logic idr);
      int gap;
      int r;
      req_valid       <= 1'b1;
      req_stream_kind <= kind;
      req_pts         <= pts;
      req_frame_num   <= fn[31:0];
      req_idr_flag    <= idr;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      r = int'($urandom_range(0, 99));
      if (r < 60) begin
         gap = 0;
      end else if (r < 90) begin
         gap = int'($urandom_range(1, 3));
      end else begin
         gap = int'($urandom_range(8, 60));
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic end_phase();
      req_valid <= 1'b0;
      @(posedge clock);
      while (verdicts_pending != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic sel, input logic [7:0] value);
      logic [kdgre_pkg::CSR_DATA_W-1:0] w;
      w = $urandom;
      if ($urandom_range(0, 1) == 0) begin
         w[31:8] = 24'd0;
      end
      w[7:0] = value;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {sel, 2'b00};
      pwdata  <= w;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) begin
         @(posedge clock);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(input logic [7:0] max_dur, input logic [7:0] def_rate);
      int          cls;
      int          r;
      int unsigned span;
      logic [1:0]  kind;
      logic [63:0] pts;
      longint      fn;
      logic        idr;
      end_phase();
      write_reg(kdgre_pkg::REG_MAX_DUR, max_dur);
      write_reg(kdgre_pkg::REG_DEFAULT_RATE, def_rate);
      span = (max_dur == 8'd0) ? 3 : int'(max_dur);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         cls = int'($urandom_range(0, 99));
         // with nothing positive logged, lean on empty slots to drain the ring
         r = (max_dur == 8'd0) ? int'($urandom_range(70, 99)) : int'($urandom_range(0, 99));
         if (r < 70) begin
            pts = gen_pts + 64'($urandom_range(1, span));
         end else if (r < 78) begin
            pts = gen_pts;
         end else if (r < 86) begin
            pts = gen_pts - 64'($urandom_range(1, 300));
         end else if (r < 94) begin
            pts = gen_pts + {56'd0, max_dur} + 64'($urandom_range(1, 400));
         end else begin
            pts = {$urandom, $urandom};
         end
         if (pts == 64'h8000_0000_0000_0000) begin
            pts = 64'h8000_0000_0000_0001;
         end
         idr  = ($urandom_range(0, 99) < 12);
         fn   = gen_fn + 1;
         kind = kdgre_pkg::KIND_AVC;
         if (cls < 62) begin
            // in-order frame
         end else if (cls < 67) begin
            fn  = gen_fn + longint'($urandom_range(2, 6));
            idr = ($urandom_range(0, 1) == 1);
         end else if (cls < 70) begin
            fn = gen_fn - longint'($urandom_range(0, 3));
            if (fn < 0) begin
               fn = 0;
            end
         end else if (cls < 72) begin
            fn = longint'($urandom & 32'h7FFF_FFFF);
         end else if (cls < 80) begin
            kind = kdgre_pkg::KIND_AUDIO;
         end else if (cls < 88) begin
            kind = KIND_OTHER_VIDEO;
         end else if (cls < 90) begin
            kind = KIND_SPARE;
         end else begin
            kind = 2'($urandom_range(0, 3));
            fn   = -1;
         end
         if (fn > 64'sd2147483647) begin
            fn = 0;
         end
         send_word(kind, pts, fn, idr);
         if (kind != kdgre_pkg::KIND_AUDIO && fn != -1) begin
            gen_fn  = fn;
            gen_pts = pts;
         end
      end
   endtask

   initial begin : stimulus
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed words at reset settings (200 max, 15 default)
      send_word(kdgre_pkg::KIND_AVC, 64'd500, -1, 1'b0);     // invalid number
      send_word(kdgre_pkg::KIND_AUDIO, 64'd9000, 3, 1'b1);
      send_word(kdgre_pkg::KIND_AVC, 64'd1000, 0, 1'b0);     // first video, still gated
      send_word(kdgre_pkg::KIND_AVC, 64'd1033, 1, 1'b1);     // IDR opens gate
      send_word(kdgre_pkg::KIND_AVC, 64'd1033, 2, 1'b0);     // zero difference
      send_word(kdgre_pkg::KIND_AVC, 64'd1000, 3, 1'b0);     // negative difference
      send_word(kdgre_pkg::KIND_AVC, 64'd1200, 4, 1'b0);     // exactly at max
      send_word(kdgre_pkg::KIND_AVC, 64'd1401, 5, 1'b0);     // just above max
      send_word(kdgre_pkg::KIND_AVC, 64'd1434, 7, 1'b0);     // number gap
      send_word(kdgre_pkg::KIND_AVC, 64'd1467, 8, 1'b0);
      send_word(kdgre_pkg::KIND_AVC, 64'd1500, 8, 1'b1);     // repeated number, IDR
      send_word(KIND_OTHER_VIDEO, 64'd1533, 100, 1'b0);
      send_word(kdgre_pkg::KIND_AVC, 64'd1566, 101, 1'b0);
      send_word(KIND_SPARE, 64'd1599, 50, 1'b1);
      send_word(kdgre_pkg::KIND_AVC, 64'h7FFF_FFFF_FFFF_FFFF, 64'sd2147483647, 1'b0);
      send_word(kdgre_pkg::KIND_AVC, 64'h8000_0000_0000_0001, 0, 1'b1);   // wraps to +2
      send_word(kdgre_pkg::KIND_AUDIO, 64'd0, -1, 1'b0);
      send_word(kdgre_pkg::KIND_AVC, 64'd77, -1, 1'b1);
      send_word(KIND_OTHER_VIDEO, 64'h8000_0000_0000_0100, -1, 1'b1);
      send_word(kdgre_pkg::KIND_AVC, 64'h8000_0000_0000_0100, 1, 1'b0);
      gen_fn  = 1;
      gen_pts = 64'h8000_0000_0000_0100;

      run_phase(8'd255, 8'd0);
      run_phase(8'd1, 8'd255);
      run_phase(8'd0, 8'd7);
      run_phase(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)));
      run_phase(8'd30, 8'd128);
      run_phase(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)));
      run_phase(8'd200, 8'd15);

      end_phase();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
